### rtl/core/pjq_pkg.sv
`timescale 1ns / 1ps

package pjq_pkg;

    localparam int FUNC_W = 2;
    localparam int TAG_W = 32;
    localparam int SIZE_W = 31;
    localparam int STATUS_W = 3;
    localparam int OCC_W = 5;

    // Promote moves a job to this slot and is refused at or before it.
    localparam int PROMOTE_SLOT = 1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQ     = 2'd0,
        FN_DEQ     = 2'd1,
        FN_CANCEL  = 2'd2,
        FN_PROMOTE = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_REFUSED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        status_t           status;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

endpackage

### rtl/core/pjq_req_if.sv
`timescale 1ns / 1ps

interface pjq_req_if
    import pjq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TAG_W-1:0]  job_tag;
    logic [SIZE_W-1:0] job_size;

    modport source (output valid, func, job_tag, job_size, input ready);
    modport sink (input valid, func, job_tag, job_size, output ready);
endinterface

### rtl/core/pjq_resp_if.sv
`timescale 1ns / 1ps

interface pjq_resp_if
    import pjq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    out_tag;
    logic [SIZE_W-1:0]   out_size;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, status, out_tag, out_size, occupancy, input ready);
    modport sink (input valid, status, out_tag, out_size, occupancy, output ready);
endinterface

### rtl/core/pjq_mem.sv
`timescale 1ns / 1ps

module pjq_mem
    import pjq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/pjq_ctrl.sv
`timescale 1ns / 1ps

module pjq_ctrl
    import pjq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    pjq_req_if.sink       req,
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res,
    output logic          mem_wr_en,
    output logic [IW-1:0] mem_wr_addr,
    output entry_t        mem_wr_data,
    output logic          mem_rd_en,
    output logic [IW-1:0] mem_rd_addr,
    input  entry_t        mem_rd_data
);

    state_t           state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic             pend_reg, pend_next;
    logic [IW-1:0]    pend_idx_reg, pend_idx_next;
    func_t            func_reg, func_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    entry_t           found_reg, found_next;
    status_t          status_reg, status_next;
    logic             hit;
    logic             issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_ptr_reg    <= rd_ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        tag_reg    <= tag_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign hit = (func_reg == FN_DEQ) || (mem_rd_data.tag == tag_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        func_next      = func_reg;
        tag_next       = tag_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        issue          = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = mem_rd_data;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = rd_ptr_reg[IW-1:0];
        req.ready      = (state_reg == S_IDLE);
        res_valid      = (state_reg == S_RESP);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next      = func_t'(req.func);
                    tag_next       = req.job_tag;
                    found_next     = '0;
                    status_next    = ST_OK;
                    rd_ptr_next    = '0;
                    cmp_valid_next = 1'b0;
                    unique case (func_t'(req.func))
                        FN_ENQ:
                        begin
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en        = 1'b1;
                                mem_wr_addr      = cnt_reg[IW-1:0];
                                mem_wr_data.tag  = req.job_tag;
                                mem_wr_data.size = req.job_size;
                                cnt_next         = cnt_reg + CW'(1);
                            end
                            state_next = S_RESP;
                        end
                        FN_DEQ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        FN_CANCEL, FN_PROMOTE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (cmp_valid_reg && hit)
                begin
                    found_next     = mem_rd_data;
                    cmp_valid_next = 1'b0;
                    pend_next      = 1'b0;
                    if (func_reg == FN_PROMOTE)
                    begin
                        if (cmp_idx_reg <= CW'(PROMOTE_SLOT))
                        begin
                            status_next = ST_REFUSED;
                            found_next  = '0;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            rd_ptr_next = cmp_idx_reg - CW'(1);
                            state_next  = S_SHIFT_UP;
                        end
                    end
                    else
                    begin
                        rd_ptr_next = cmp_idx_reg + CW'(1);
                        state_next  = S_SHIFT_DN;
                    end
                end
                else if (cmp_valid_reg && (cmp_idx_reg == cnt_reg - CW'(1)))
                begin
                    cmp_valid_next = 1'b0;
                    status_next    = ST_NOT_FOUND;
                    state_next     = S_RESP;
                end
                else
                begin
                    issue          = (rd_ptr_reg < cnt_reg);
                    mem_rd_en      = issue;
                    cmp_valid_next = issue;
                    cmp_idx_next   = rd_ptr_reg;
                    if (issue)
                    begin
                        rd_ptr_next = rd_ptr_reg + CW'(1);
                    end
                end
            end

            S_SHIFT_DN:
            begin
                // Writes trail the reads by one entry, so no read sees a new value.
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pend_idx_reg - IW'(1);
                end
                issue     = (rd_ptr_reg < cnt_reg);
                mem_rd_en = issue;
                pend_next = issue;
                if (issue)
                begin
                    pend_idx_next = rd_ptr_reg[IW-1:0];
                    rd_ptr_next   = rd_ptr_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_SHIFT_UP:
            begin
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pend_idx_reg + IW'(1);
                end
                issue     = (rd_ptr_reg != '0);
                mem_rd_en = issue;
                pend_next = issue;
                if (issue)
                begin
                    pend_idx_next = rd_ptr_reg[IW-1:0];
                    rd_ptr_next   = rd_ptr_reg - CW'(1);
                end
                else if (!pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = IW'(PROMOTE_SLOT);
                    mem_wr_data = found_reg;
                    state_next  = S_RESP;
                end
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status    = status_reg;
        res.tag       = found_reg.tag;
        res.size      = found_reg.size;
        res.occupancy = OCC_W'(cnt_reg);
    end

endmodule

### rtl/core/print_job_queue_top.sv
`timescale 1ns / 1ps

// Channel  Modport  Fields
// req      sink     func, job_tag, job_size
// resp     source   status, out_tag, out_size, occupancy
//
// Enqueue, and any request refused at once, goes from idle straight to the response state.
// Dequeue and cancel search for the job, then shift the later jobs down; promote searches,
// then shifts the jobs from the promote slot to the job up; one port of the job memory does both.
// A miss compares every job in the queue before it answers not found.
// Reset clears the count and the sequencer; the job memory is not cleared.
// A new request is taken while the previous response waits in the output register.

module print_job_queue_top
    import pjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    pjq_req_if.sink    req,
    pjq_resp_if.source resp
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    entry_t        mem_wr_data;
    logic          mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    entry_t        mem_rd_data;

    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    pjq_ctrl #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    pjq_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign res_ready = !out_valid_reg || resp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (resp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign resp.valid     = out_valid_reg;
    assign resp.status    = out_reg.status;
    assign resp.out_tag   = out_reg.tag;
    assign resp.out_size  = out_reg.size;
    assign resp.occupancy = out_reg.occupancy;

endmodule
